// File: hw/rtl/wsup_pkg.sv
// ----------------------------------------------------------------------------
// wsup_pkg : shared types for the task watchdog supervisor
// Event codes, controller states and the control word that walks the slot
// chain.
// ----------------------------------------------------------------------------
`default_nettype none

package wsup_pkg;

    localparam int EXP_W = 4;

    typedef enum logic [2:0] {
        KIND_REGISTER   = 3'd0,
        KIND_UNREGISTER = 3'd1,
        KIND_FEED       = 3'd2,
        KIND_PAUSE      = 3'd3,
        KIND_RESUME     = 3'd4,
        KIND_TICK       = 3'd5,
        KIND_SCAN       = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic  vld;
        kind_t kind;
        logic  en;
        logic  done;
    } ctrl_t;

    typedef struct packed {
        logic             accepted;
        logic             refresh;
        logic             reset_request;
        logic [EXP_W-1:0] expired_slot;
    } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/task_watchdog_supervisor.sv
// ----------------------------------------------------------------------------
// task_watchdog_supervisor : software task watchdog monitor
// Watch table of SLOTS tasks built as a chain of slot cells, with a tick
// counter, a pause flag and a result register.
// ----------------------------------------------------------------------------
// Usage: each s_ word is one event (register, unregister, feed, pause,
// resume, tick, scan) and yields exactly one m_ word. Both channels use
// valid/ready. An accepted word is latched and then walks the slot chain,
// one cell per cycle, so the lowest matching or free slot acts first and
// the first expired slot is named on a scan.
// An accepted word passes the input register, the register in each slot cell
// and the result register on its way to m_valid. One event is in the chain
// at a time: no new event is taken until the last one has left the chain.
// The result register is separate from the chain: a new event is taken
// while a result still waits on m_ready. If the receiver stalls long enough
// for the next result to finish, that result is parked and the input side
// holds s_ready low until it has moved to the output.
// Reset clears the table, the tick counter and the pause flag; the block is
// ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module task_watchdog_supervisor
    import wsup_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_kind,
    input  wire logic [7:0]  s_task_id,
    input  wire logic [31:0] s_timeout,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_accepted,
    output logic             m_refresh,
    output logic             m_reset_request,
    output logic [3:0]       m_expired_slot,
    output logic             m_paused
);

    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] tick_reg;
    logic                 pause_reg;
    ctrl_t                item_ctrl_reg, item_ctrl_next;
    logic [ID_BITS-1:0]   item_id_reg;
    logic [TIME_BITS-1:0] item_lim_reg;
    res_t                 pend_reg;
    res_t                 out_reg;
    res_t                 end_res;
    logic                 m_valid_reg;
    logic                 m_paused_reg;
    logic                 accept;
    logic                 out_free;
    logic                 load_out;
    logic                 load_pend;
    logic                 from_pend;
    kind_t                in_kind;
    logic [ID_BITS-1:0]   in_id;
    logic                 feed_or_slot;

    ctrl_t                ctrl_c [SLOTS+1];
    logic [ID_BITS-1:0]   id_c   [SLOTS+1];
    logic [TIME_BITS-1:0] lim_c  [SLOTS+1];
    logic [EXP_W-1:0]     idx_c  [SLOTS+1];

    assign in_kind  = kind_t'(s_kind);
    assign in_id    = ID_BITS'(s_task_id);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        item_ctrl_next      = item_ctrl_reg;
        item_ctrl_next.vld  = accept;
        if (accept) begin
            item_ctrl_next.kind = in_kind;
            item_ctrl_next.done = 1'b0;
            if (in_kind == KIND_SCAN) begin
                item_ctrl_next.en = !pause_reg;
            end else if (in_kind == KIND_FEED) begin
                item_ctrl_next.en = (in_id != '0) && !pause_reg;
            end else begin
                item_ctrl_next.en = (in_id != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            pause_reg     <= 1'b0;
            item_ctrl_reg <= '0;
        end else begin
            item_ctrl_reg <= item_ctrl_next;
            if (accept) begin
                if (in_kind == KIND_TICK) begin
                    tick_reg <= tick_reg + 1'b1;
                end
                if (in_kind == KIND_PAUSE) begin
                    pause_reg <= 1'b1;
                end else if (in_kind == KIND_RESUME) begin
                    pause_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_id_reg  <= in_id;
            item_lim_reg <= TIME_BITS'(s_timeout);
        end
    end

    assign ctrl_c[0] = item_ctrl_reg;
    assign id_c[0]   = item_id_reg;
    assign lim_c[0]  = item_lim_reg;
    assign idx_c[0]  = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        wsup_cell #(
            .ID_BITS   (ID_BITS),
            .TIME_BITS (TIME_BITS),
            .INDEX     (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .now_i   (tick_reg),
            .ctrl_i  (ctrl_c[i]),
            .id_i    (id_c[i]),
            .lim_i   (lim_c[i]),
            .idx_i   (idx_c[i]),
            .ctrl_o  (ctrl_c[i+1]),
            .id_o    (id_c[i+1]),
            .lim_o   (lim_c[i+1]),
            .idx_o   (idx_c[i+1])
        );
    end

    assign feed_or_slot = (ctrl_c[SLOTS].kind == KIND_REGISTER) ||
                          (ctrl_c[SLOTS].kind == KIND_UNREGISTER) ||
                          (ctrl_c[SLOTS].kind == KIND_FEED);

    always_comb begin
        end_res.accepted      = feed_or_slot && ctrl_c[SLOTS].done;
        end_res.refresh       = (ctrl_c[SLOTS].kind == KIND_SCAN) && !ctrl_c[SLOTS].done;
        end_res.reset_request = (ctrl_c[SLOTS].kind == KIND_SCAN) && ctrl_c[SLOTS].done;
        end_res.expired_slot  = end_res.reset_request ? idx_c[SLOTS] : '0;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (ctrl_c[SLOTS].vld) begin
                    state_next = out_free ? ST_IDLE : ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        load_out  = 1'b0;
        load_pend = 1'b0;
        from_pend = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_RUN: begin
                load_out  = ctrl_c[SLOTS].vld && out_free;
                load_pend = ctrl_c[SLOTS].vld && !out_free;
            end
            ST_WAIT: begin
                load_out  = out_free;
                from_pend = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_pend) begin
            pend_reg <= end_res;
        end
        if (load_out) begin
            out_reg      <= from_pend ? pend_reg : end_res;
            m_paused_reg <= pause_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = out_reg.accepted;
    assign m_refresh       = out_reg.refresh;
    assign m_reset_request = out_reg.reset_request;
    assign m_expired_slot  = out_reg.expired_slot;
    assign m_paused        = m_paused_reg;

    a_end_in_run : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_c[SLOTS].vld |-> state_reg == ST_RUN)
        else $error("chain word left the last cell outside a run");

    a_accept_launch : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> item_ctrl_reg.vld && state_reg == ST_RUN)
        else $error("accepted word did not enter the chain");

    a_scan_excl : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_refresh && m_reset_request))
        else $error("refresh and reset request both set");

    a_acc_not_scan : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_accepted) |-> (!m_refresh && !m_reset_request))
        else $error("accepted set on a scan result");

endmodule

`default_nettype wire

// File: hw/rtl/wsup_cell.sv
// ----------------------------------------------------------------------------
// wsup_cell : one slot of the watch table
// Holds a slot and acts on the event word as it passes, then registers the
// word and hands it on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wsup_cell
    import wsup_pkg::*;
#(
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 32,
    parameter int INDEX     = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [TIME_BITS-1:0] now_i,
    input  wire ctrl_t                ctrl_i,
    input  wire logic [ID_BITS-1:0]   id_i,
    input  wire logic [TIME_BITS-1:0] lim_i,
    input  wire logic [EXP_W-1:0]     idx_i,
    output ctrl_t                     ctrl_o,
    output logic [ID_BITS-1:0]        id_o,
    output logic [TIME_BITS-1:0]      lim_o,
    output logic [EXP_W-1:0]          idx_o
);

    logic                 valid_reg, valid_next;
    logic [ID_BITS-1:0]   task_reg, task_next;
    logic [TIME_BITS-1:0] limit_reg, limit_next;
    logic [TIME_BITS-1:0] stamp_reg, stamp_next;
    ctrl_t                ctrl_reg, ctrl_next;
    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] lim_reg;
    logic [EXP_W-1:0]     idx_reg, idx_next;
    logic                 match;
    logic                 expired;
    logic                 live;

    assign match   = valid_reg && (task_reg == id_i);
    assign expired = valid_reg && ((now_i - stamp_reg) > limit_reg);
    assign live    = ctrl_i.vld && ctrl_i.en && !ctrl_i.done;

    always_comb begin
        valid_next = valid_reg;
        task_next  = task_reg;
        limit_next = limit_reg;
        stamp_next = stamp_reg;
        ctrl_next  = ctrl_i;
        idx_next   = idx_i;
        if (ctrl_i.vld) begin
            case (ctrl_i.kind)
                KIND_REGISTER: begin
                    if (live && !valid_reg) begin
                        valid_next     = 1'b1;
                        task_next      = id_i;
                        limit_next     = lim_i;
                        stamp_next     = now_i;
                        ctrl_next.done = 1'b1;
                    end
                end
                KIND_UNREGISTER: begin
                    if (live && match) begin
                        valid_next     = 1'b0;
                        task_next      = '0;
                        ctrl_next.done = 1'b1;
                    end
                end
                KIND_FEED: begin
                    if (live && match) begin
                        stamp_next     = now_i;
                        ctrl_next.done = 1'b1;
                    end
                end
                KIND_RESUME: begin
                    if (valid_reg) begin
                        stamp_next = now_i;
                    end
                end
                KIND_SCAN: begin
                    if (live && expired) begin
                        ctrl_next.done = 1'b1;
                        idx_next       = EXP_W'(INDEX);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            task_reg  <= '0;
            ctrl_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            task_reg  <= task_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg <= limit_next;
        stamp_reg <= stamp_next;
        id_reg    <= id_i;
        lim_reg   <= lim_i;
        idx_reg   <= idx_next;
    end

    assign ctrl_o = ctrl_reg;
    assign id_o   = id_reg;
    assign lim_o  = lim_reg;
    assign idx_o  = idx_reg;

endmodule

`default_nettype wire
